[src/assert_macros.svh]
// Assertion macros shared by the change-making RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/gcc_pkg.sv]
// Shared constants and codes for the greedy change-making block.
package gcc_pkg;

    // Fixed field widths of the item ports
    localparam int OP_W     = 2;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 40;
    localparam int STATUS_W = 2;

    // Default widths of the stored state
    localparam int VALUE_WIDTH_DEF = 40;
    localparam int DENOM_WIDTH_DEF = 16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_DEPOSIT = 2'd0;
    localparam logic [OP_W-1:0] OP_PAYOUT  = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SAT  = 2'd2;

endpackage

[src/greedy_coin_change.sv]
// Greedy change-making unit: one result per item. Deposits run a bit-serial
// shift-add multiply of denomination by count (one count bit a cycle), then a
// saturating add; payouts run the bit-serial divider (one quotient bit a
// cycle), then store the remainder and add the piece total with saturation;
// restart, zero denomination and the unused op code go straight to the result
// stage. One item is in work at a time; the result register lets the next item
// enter while a finished result waits to be taken.
`include "assert_macros.svh"

module greedy_coin_change
    import gcc_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int DENOM_WIDTH = DENOM_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [OP_W-1:0]     op,
    input  logic [IN_W-1:0]     denomination,
    input  logic [IN_W-1:0]     count,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [OUT_W-1:0]    pieces,
    output logic [OUT_W-1:0]    remaining,
    output logic [OUT_W-1:0]    pieces_total,
    output logic [STATUS_W-1:0] status
);

    // Denomination bits that matter, product width, extension width
    localparam int DU = (DENOM_WIDTH < IN_W) ? DENOM_WIDTH : IN_W;
    localparam int PW = DU + IN_W;
    localparam int EW = (VALUE_WIDTH > OUT_W) ? VALUE_WIDTH : OUT_W;
    localparam int SW = $clog2(IN_W + 1);
    localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DEP,
        S_DIV,
        S_TOT,
        S_OUT
    } state_t;

    state_t                   state_reg;
    logic [DU-1:0]            denom_reg;
    logic [IN_W-1:0]          cnt_reg;
    logic [PW-1:0]            acc_reg;
    logic [SW-1:0]            step_reg;
    logic [VALUE_WIDTH-1:0]   held_reg;
    logic [VALUE_WIDTH-1:0]   issued_reg;
    logic [VALUE_WIDTH-1:0]   pieces_reg;
    logic [STATUS_W-1:0]      status_reg;
    logic                     div_start_reg;
    logic                     out_valid_reg;
    logic [OUT_W-1:0]         pieces_out_reg;
    logic [OUT_W-1:0]         remaining_out_reg;
    logic [OUT_W-1:0]         total_out_reg;
    logic [STATUS_W-1:0]      status_out_reg;

    logic                     in_xfer;
    logic [DU-1:0]            denom_in;
    logic [PW-1:0]            acc_next;
    logic [VALUE_WIDTH:0]     dep_sum;
    logic [VALUE_WIDTH:0]     tot_sum;
    logic                     div_done;
    logic [VALUE_WIDTH-1:0]   div_quot;
    logic [DU-1:0]            div_rem;
    logic [EW-1:0]            pieces_ext;
    logic [EW-1:0]            held_ext;
    logic [EW-1:0]            issued_ext;

    // Input transfer and narrowed denomination
    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign denom_in = denomination[DU-1:0];

    // Shift-add multiply, count MSB first
    assign acc_next = {acc_reg[PW-2:0], 1'b0} + (cnt_reg[IN_W-1] ? PW'(denom_reg) : '0);

    // Saturating adders for held value and piece total
    assign dep_sum = {1'b0, held_reg} + (VALUE_WIDTH + 1)'(acc_reg);
    assign tot_sum = {1'b0, issued_reg} + {1'b0, pieces_reg};

    // Fit stored values to the output field width
    assign pieces_ext = EW'(pieces_reg);
    assign held_ext   = EW'(held_reg);
    assign issued_ext = EW'(issued_reg);

    gcc_divider #(
        .VW (VALUE_WIDTH),
        .DW (DU)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start_reg),
        .dividend  (held_reg),
        .divisor   (denom_reg),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Sequencer, state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            held_reg          <= '0;
            issued_reg        <= '0;
            div_start_reg     <= 1'b0;
            out_valid_reg     <= 1'b0;
            step_reg          <= '0;
            denom_reg         <= '0;
            cnt_reg           <= '0;
            acc_reg           <= '0;
            pieces_reg        <= '0;
            status_reg        <= STATUS_OK;
            pieces_out_reg    <= '0;
            remaining_out_reg <= '0;
            total_out_reg     <= '0;
            status_out_reg    <= STATUS_OK;
        end
        else
        begin
            // divider kicks off right after a payout with a usable denomination
            div_start_reg <= in_xfer && (op == OP_PAYOUT) && (denom_in != '0);
            // a taken result clears valid unless a new one loads this cycle
            if (out_valid_reg && out_ready && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        denom_reg  <= denom_in;
                        cnt_reg    <= count;
                        acc_reg    <= '0;
                        step_reg   <= SW'(IN_W);
                        pieces_reg <= '0;
                        priority if (op == OP_RESTART)
                        begin
                            held_reg   <= '0;
                            issued_reg <= '0;
                            status_reg <= STATUS_OK;
                            state_reg  <= S_OUT;
                        end
                        else if ((op == OP_DEPOSIT || op == OP_PAYOUT) && denom_in == '0)
                        begin
                            status_reg <= STATUS_ZERO;
                            state_reg  <= S_OUT;
                        end
                        else if (op == OP_DEPOSIT)
                        begin
                            status_reg <= STATUS_OK;
                            state_reg  <= S_MUL;
                        end
                        else if (op == OP_PAYOUT)
                        begin
                            status_reg <= STATUS_OK;
                            state_reg  <= S_DIV;
                        end
                        else
                        begin
                            status_reg <= STATUS_OK;
                            state_reg  <= S_OUT;
                        end
                    end
                end
                S_MUL:
                begin
                    acc_reg  <= acc_next;
                    cnt_reg  <= {cnt_reg[IN_W-2:0], 1'b0};
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == SW'(1))
                    begin
                        state_reg <= S_DEP;
                    end
                end
                S_DEP:
                begin
                    if (dep_sum[VALUE_WIDTH])
                    begin
                        held_reg   <= VALUE_MAX;
                        status_reg <= STATUS_SAT;
                    end
                    else
                    begin
                        held_reg <= dep_sum[VALUE_WIDTH-1:0];
                    end
                    state_reg <= S_OUT;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        pieces_reg <= div_quot;
                        held_reg   <= VALUE_WIDTH'(div_rem);
                        state_reg  <= S_TOT;
                    end
                end
                S_TOT:
                begin
                    if (tot_sum[VALUE_WIDTH])
                    begin
                        issued_reg <= VALUE_MAX;
                        status_reg <= STATUS_SAT;
                    end
                    else
                    begin
                        issued_reg <= tot_sum[VALUE_WIDTH-1:0];
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        pieces_out_reg    <= pieces_ext[OUT_W-1:0];
                        remaining_out_reg <= held_ext[OUT_W-1:0];
                        total_out_reg     <= issued_ext[OUT_W-1:0];
                        status_out_reg    <= status_reg;
                        out_valid_reg     <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign pieces       = pieces_out_reg;
    assign remaining    = remaining_out_reg;
    assign pieces_total = total_out_reg;
    assign status       = status_out_reg;

    `ASSERT_NEXT(a_busy_after_xfer, clk, rst_n, in_xfer, !in_ready)
    `ASSERT_NEXT(a_restart_clears, clk, rst_n, in_xfer && op == OP_RESTART, ~|(held_reg | issued_reg))

endmodule

[src/gcc_divider.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
`include "assert_macros.svh"

module gcc_divider
    import gcc_pkg::*;
#(
    parameter int VW = VALUE_WIDTH_DEF,
    parameter int DW = DENOM_WIDTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [VW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [VW-1:0] quotient,
    output logic [DW-1:0] remainder
);

    localparam int CW = $clog2(VW + 1);

    logic [VW-1:0] q_reg;
    logic [DW-1:0] rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [DW:0]   trial;
    logic          ge;
    logic [DW:0]   diff;

    // One restoring step: bring in the next dividend bit and try a subtract
    always_comb
    begin
        trial = {rem_reg, q_reg[VW-1]};
        ge    = (trial >= {1'b0, divisor});
        diff  = trial - {1'b0, divisor};
    end

    // Control: step counter and busy/done flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CW'(VW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out the top, quotient bits shift in the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[VW-2:0], ge};
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = rem_reg;

    `ASSERT_SAME(a_no_restart_busy, clk, rst_n, start, !busy_reg)
    `ASSERT_SAME(a_rem_below_divisor, clk, rst_n, done_reg, rem_reg < divisor)

endmodule

[bench/gcc_change_checker.sv]
// Result checker for the greedy change-making block: predicts every transfer and compares.
module gcc_change_checker
    import gcc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [OP_W-1:0]     op,
    input  logic [IN_W-1:0]     denomination,
    input  logic [IN_W-1:0]     count,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [OUT_W-1:0]    pieces,
    input  logic [OUT_W-1:0]    remaining,
    input  logic [OUT_W-1:0]    pieces_total,
    input  logic [STATUS_W-1:0] status,
    output int                  mismatches,
    output int                  waiting,
    output int                  results_seen,
    output int                  saturated_seen,
    output int                  zero_denom_seen
);

    localparam int VW = VALUE_WIDTH_DEF;
    localparam int DW = DENOM_WIDTH_DEF;
    localparam logic [VW-1:0] VALUE_MAX = '1;
    // keep the log short when the block is badly off
    localparam int PRINT_CAP = 100;

    typedef struct packed {
        logic [OUT_W-1:0]    pieces;
        logic [OUT_W-1:0]    remaining;
        logic [OUT_W-1:0]    total;
        logic [STATUS_W-1:0] status;
    } change_t;

    change_t       expected_change[$];
    change_t       got;
    change_t       want;
    logic [VW-1:0] bank_value = '0;
    logic [VW-1:0] paid_total = '0;

    initial
    begin
        mismatches      = 0;
        waiting         = 0;
        results_seen    = 0;
        saturated_seen  = 0;
        zero_denom_seen = 0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                   input logic [63:0] want_v);
        if (mismatches < PRINT_CAP)
            $display("%0t: %s: got %0h, expected %0h", $time, what, got_v, want_v);
        mismatches++;
    endtask

    // add with clamp at the top of the value range; msb flags the clamp
    function automatic logic [VW:0] add_clamped(input logic [VW-1:0] a,
                                               input logic [VW-1:0] b);
        logic [VW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum[VW])
            return {1'b1, VALUE_MAX};
        return sum;
    endfunction

    // next result for one item; advances the bank and the paid total
    function automatic change_t predict_change(input logic [OP_W-1:0] code,
                                               input logic [IN_W-1:0] denom_in,
                                               input logic [IN_W-1:0] cnt);
        logic [DW-1:0] denom;
        logic [VW-1:0] product;
        logic [VW-1:0] quotient;
        logic [VW:0]   clamped;
        change_t       res;
        denom = denom_in[DW-1:0];
        res   = '0;
        res.status = STATUS_OK;
        case (code)
            OP_DEPOSIT:
            begin
                if (denom == '0)
                    res.status = STATUS_ZERO;
                else
                begin
                    product    = VW'(denom) * VW'(cnt);
                    clamped    = add_clamped(bank_value, product);
                    bank_value = clamped[VW-1:0];
                    if (clamped[VW])
                        res.status = STATUS_SAT;
                end
            end
            OP_PAYOUT:
            begin
                if (denom == '0)
                    res.status = STATUS_ZERO;
                else
                begin
                    quotient   = bank_value / VW'(denom);
                    bank_value = bank_value % VW'(denom);
                    res.pieces = OUT_W'(quotient);
                    clamped    = add_clamped(paid_total, quotient);
                    paid_total = clamped[VW-1:0];
                    if (clamped[VW])
                        res.status = STATUS_SAT;
                end
            end
            OP_RESTART:
            begin
                bank_value = '0;
                paid_total = '0;
            end
            default: ;  // spare code leaves the state alone
        endcase
        res.remaining = OUT_W'(bank_value);
        res.total     = OUT_W'(paid_total);
        return res;
    endfunction

    // watch both channels; the result side goes first so a transfer never
    // meets the expectation of the item taken at the same edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_change.delete();
            bank_value = '0;
            paid_total = '0;
            waiting <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                got = '{pieces, remaining, pieces_total, status};
                if (expected_change.size() == 0)
                    report_mismatch("result with nothing expected", 64'(got.pieces), 64'(0));
                else
                begin
                    want = expected_change.pop_front();
                    if (got.pieces !== want.pieces)
                        report_mismatch("pieces", 64'(got.pieces), 64'(want.pieces));
                    if (got.remaining !== want.remaining)
                        report_mismatch("remaining", 64'(got.remaining),
                                        64'(want.remaining));
                    if (got.total !== want.total)
                        report_mismatch("pieces_total", 64'(got.total), 64'(want.total));
                    if (got.status !== want.status)
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                end
            end
            if (in_valid && in_ready)
            begin
                want = predict_change(op, denomination, count);
                if (want.status == STATUS_SAT)
                    saturated_seen++;
                if (want.status == STATUS_ZERO)
                    zero_denom_seen++;
                expected_change.push_back(want);
            end
            waiting <= expected_change.size();
        end
    end

endmodule

[bench/tb.sv]
// Top of the change-making bench: clock, reset, item stimulus, result sink and verdict.
module tb;
    import gcc_pkg::*;

    // op code with no function
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int MIXED_LEAD    = 700;
    localparam int FILL_DEPOSITS = 300;
    localparam int DRAIN_CYCLES  = 64;
    localparam int MAX_GAP       = 11;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [OP_W-1:0]     op;
    logic [IN_W-1:0]     denomination;
    logic [IN_W-1:0]     count;
    logic                out_valid;
    logic                out_ready;
    logic [OUT_W-1:0]    pieces;
    logic [OUT_W-1:0]    remaining;
    logic [OUT_W-1:0]    pieces_total;
    logic [STATUS_W-1:0] status;

    int mismatches;
    int waiting;
    int results_seen;
    int saturated_seen;
    int zero_denom_seen;
    int items_sent = 0;
    int random_start;
    bit send_calm = 1'b0;
    bit take_calm = 1'b0;

    greedy_coin_change dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .denomination (denomination),
        .count        (count),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pieces       (pieces),
        .remaining    (remaining),
        .pieces_total (pieces_total),
        .status       (status)
    );

    gcc_change_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .denomination    (denomination),
        .count           (count),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pieces          (pieces),
        .remaining       (remaining),
        .pieces_total    (pieces_total),
        .status          (status),
        .mismatches      (mismatches),
        .waiting         (waiting),
        .results_seen    (results_seen),
        .saturated_seen  (saturated_seen),
        .zero_denom_seen (zero_denom_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #2500000;
        $display("greedy_coin_change: mismatch");
        $finish;
    end

    // one item transfer; valid stays up across back-to-back items
    task automatic send_item(input logic [OP_W-1:0] code, input logic [IN_W-1:0] denom_v,
                             input logic [IN_W-1:0] cnt_v);
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_calm = ~send_calm;
        gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op           <= code;
        denomination <= denom_v;
        count        <= cnt_v;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    // operand mix: small (zero included), single bits, near full scale, anything
    function automatic logic [IN_W-1:0] draw_operand();
        case ($urandom_range(0, 4))
            0:       return IN_W'($urandom_range(0, 15));
            1:       return IN_W'(1) << $urandom_range(0, IN_W - 1);
            2:       return IN_W'($urandom_range(16'hF000, 16'hFFFF));
            default: return IN_W'($urandom);
        endcase
    endfunction

    function automatic logic [OP_W-1:0] draw_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return OP_DEPOSIT;
        if (r < 88)
            return OP_PAYOUT;
        if (r < 95)
            return OP_RESTART;
        return OP_SPARE;
    endfunction

    // result sink with random stalls
    initial
    begin : result_sink
        int gap;
        out_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                take_calm = ~take_calm;
            gap = take_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // reset, stimulus, drain and verdict
    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        op           <= OP_DEPOSIT;
        denomination <= '0;
        count        <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed corners
        send_item(OP_SPARE, '0, '0);                  // spare code on an empty bank
        send_item(OP_DEPOSIT, '0, '0);                // zero denomination with zero count
        send_item(OP_PAYOUT, '0, '1);                 // payout in zero denomination
        send_item(OP_DEPOSIT, '0, '1);
        send_item(OP_DEPOSIT, '1, '1);                // largest single deposit
        send_item(OP_DEPOSIT, 16'd1, '0);             // zero count
        send_item(OP_DEPOSIT, 16'd1, 16'd1);
        send_item(OP_PAYOUT, '1, '1);                 // largest denomination
        send_item(OP_SPARE, '1, '1);                  // spare code reports current state
        send_item(OP_PAYOUT, 16'd1, '0);              // everything out in unit pieces
        send_item(OP_PAYOUT, 16'd1, '0);              // nothing left to pay
        send_item(OP_DEPOSIT, 16'h8000, 16'h8000);
        send_item(OP_PAYOUT, 16'h5555, 16'hAAAA);
        send_item(OP_PAYOUT, 16'd3, '0);
        send_item(OP_RESTART, '1, '1);                // restart clears bank and total
        send_item(OP_SPARE, 16'h5555, 16'hAAAA);
        send_item(OP_DEPOSIT, 16'hAAAA, 16'h5555);
        send_item(OP_PAYOUT, 16'd7, 16'h5555);
        send_item(OP_RESTART, '0, '0);

        // mixed traffic, then two fills without restart: the first clamps the
        // bank, the second pushes the paid total over its range as well
        random_start = items_sent;
        repeat (MIXED_LEAD) send_item(draw_op(), draw_operand(), draw_operand());
        for (int f = 0; f < 2; f++)
        begin
            repeat (FILL_DEPOSITS)
                send_item(OP_DEPOSIT, IN_W'($urandom_range(16'hFC00, 16'hFFFF)),
                          IN_W'($urandom_range(16'hFC00, 16'hFFFF)));
            send_item(OP_PAYOUT, 16'd1, IN_W'($urandom));
        end
        while (items_sent - random_start < RANDOM_ITEMS)
            send_item(draw_op(), draw_operand(), draw_operand());
        in_valid <= 1'b0;

        // drain
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d items sent, %0d results checked", items_sent, results_seen);
        $display("run: %0d zero-denomination and %0d saturated results among them",
                 zero_denom_seen, saturated_seen);
        if (mismatches == 0)
            $display("greedy_coin_change: match");
        else
            $display("greedy_coin_change: mismatch");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/gcc_pkg.sv
src/gcc_divider.sv
src/greedy_coin_change.sv
bench/gcc_change_checker.sv
bench/tb.sv
